@@ rtl/pltl_pkg.sv @@
package pltl_pkg;

  // Width of every scalar and channel value (unsigned Q0.16).
  localparam int unsigned ValBits = 16;
  // Table depth and the widths that follow from it.
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxBits = 4;
  localparam int unsigned CntBits = 5;
  // Red, green, blue, alpha.
  localparam int unsigned NumChan = 4;
  localparam int unsigned AlphaChan = 3;

  typedef logic [ValBits-1:0] val_t;
  typedef logic [NumChan-1:0][ValBits-1:0] chan_t;

  // One stored control point.
  typedef struct packed {
    val_t  pos;
    chan_t chan;
  } point_t;

  // Configuration register indexes.
  typedef enum logic {
    RegPointsInUse = 1'b0,
    RegAssociate   = 1'b1
  } reg_idx_e;

  // Item kinds.
  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqLookup = 1'b1;

endpackage

@@ rtl/piecewise_linear_transfer_lookup.sv @@
// Channel | Direction | Handshake                  | Word
// in      | input     | in_valid_i / in_stall_o    | write of a point or a lookup
// out     | output    | out_valid_o / out_stall_i  | interpolated RGBA and in_range
// cfg     | input     | cfg_we_i                   | points_in_use, associate_mode
//
// A word enters every cycle while the output is not stalled; a lookup result leaves
// through six stages around the 16-stage quotient pipeline, the first of which loads
// at the edge that accepts it.
// Write words update the table at acceptance and give no result.
// Reset clears the valid bits and the configuration registers; the table is undefined until written.
// A stall on the output while a result waits there freezes the whole pipeline and stalls the input.
module piecewise_linear_transfer_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [pltl_pkg::CntBits-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [pltl_pkg::IdxBits-1:0]    point_index_i,
  input  logic [pltl_pkg::ValBits-1:0]    point_scalar_i,
  input  logic [pltl_pkg::ValBits-1:0]    point_red_i,
  input  logic [pltl_pkg::ValBits-1:0]    point_green_i,
  input  logic [pltl_pkg::ValBits-1:0]    point_blue_i,
  input  logic [pltl_pkg::ValBits-1:0]    point_alpha_i,
  input  logic [pltl_pkg::ValBits-1:0]    sample_scalar_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pltl_pkg::ValBits-1:0]    out_red_o,
  output logic [pltl_pkg::ValBits-1:0]    out_green_o,
  output logic [pltl_pkg::ValBits-1:0]    out_blue_o,
  output logic [pltl_pkg::ValBits-1:0]    out_alpha_o,
  output logic                            in_range_o
);
  import pltl_pkg::*;

  localparam int unsigned DivStages = ValBits;

  logic adv;
  logic in_acc;

  // The pipeline moves as one unless a finished word waits at the output.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  // Configuration registers.
  logic [CntBits-1:0] pts_q;
  logic               assoc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q   <= '0;
      assoc_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegPointsInUse: pts_q   <= cfg_data_i;
        RegAssociate:   assoc_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Point table: positions in flops for the parallel compare, and a
  // copy of whole points in a two-read-port memory.
  val_t   pos_q [MaxPoints];
  point_t mem_q [MaxPoints];
  point_t wr_point;

  assign wr_point.pos  = point_scalar_i;
  assign wr_point.chan = {point_alpha_i, point_blue_i, point_green_i, point_red_i};

  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == ReqWrite) begin
      pos_q[point_index_i] <= point_scalar_i;
      mem_q[point_index_i] <= wr_point;
    end
  end

  // Stage 1: compare the sample against every point and pick the segment.
  logic [CntBits-1:0]   n_cl;
  logic [MaxPoints-1:0] ge_all;
  logic [IdxBits-1:0]   k_sel;
  logic [IdxBits-1:0]   last_idx;
  logic                 range_ok;

  always_comb begin
    n_cl     = (pts_q > CntBits'(MaxPoints)) ? CntBits'(MaxPoints) : pts_q;
    last_idx = IdxBits'(n_cl - CntBits'(1));
    for (int j = 0; j < MaxPoints; j++) begin
      ge_all[j] = (pos_q[j] >= sample_scalar_i);
    end
    k_sel = last_idx;
    for (int j = MaxPoints - 1; j >= 0; j--) begin
      if (ge_all[j] && (CntBits'(j) < n_cl)) begin
        k_sel = IdxBits'(j);
      end
    end
    range_ok = (n_cl >= CntBits'(2)) && (sample_scalar_i >= pos_q[0]) && ge_all[last_idx];
  end

  logic               v1_q, inr1_q;
  logic [IdxBits-1:0] k1_q;
  val_t               samp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc && (req_type_i == ReqLookup);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inr1_q  <= range_ok;
      k1_q    <= k_sel;
      samp1_q <= sample_scalar_i;
    end
  end

  // Stage 2: read the left and right points of the segment.
  logic   v2_q, inr2_q, kz2_q;
  point_t rowl2_q, rowr2_q;
  val_t   samp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rowr2_q <= mem_q[k1_q];
      rowl2_q <= mem_q[(k1_q == '0) ? k1_q : k1_q - IdxBits'(1)];
      kz2_q   <= (k1_q == '0);
      inr2_q  <= inr1_q;
      samp2_q <= samp1_q;
    end
  end

  // Stage 3: segment width and offset. A degenerate segment, the first
  // point or a sample on the left point takes the right point as is,
  // which a width and offset of one reproduce.
  logic take_r;
  val_t den_c, num_c;

  always_comb begin
    take_r = kz2_q || (rowr2_q.pos <= rowl2_q.pos) || (samp2_q <= rowl2_q.pos);
    den_c  = rowr2_q.pos - rowl2_q.pos;
    num_c  = samp2_q - rowl2_q.pos;
    if (num_c > den_c) begin
      num_c = den_c;
    end
    if (take_r) begin
      den_c = val_t'(1);
      num_c = val_t'(1);
    end
  end

  logic  v3_q, inr3_q;
  val_t  den3_q, num3_q, wnum3_q;
  chan_t yl3_q, yr3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inr3_q  <= inr2_q;
      den3_q  <= den_c;
      num3_q  <= num_c;
      wnum3_q <= den_c - num_c;
      yl3_q   <= rowl2_q.chan;
      yr3_q   <= rowr2_q.chan;
    end
  end

  // Stage 4: weight both ends of every channel.
  logic                 v4_q, inr4_q;
  val_t                 den4_q;
  logic [2*ValBits-1:0] pl4_q [NumChan];
  logic [2*ValBits-1:0] pr4_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inr4_q <= inr3_q;
      den4_q <= den3_q;
      for (int c = 0; c < NumChan; c++) begin
        pl4_q[c] <= yl3_q[c] * wnum3_q;
        pr4_q[c] <= yr3_q[c] * num3_q;
      end
    end
  end

  // Stage 5: sum with half the width for round-to-nearest.
  logic               v5_q, inr5_q;
  val_t               den5_q;
  logic [2*ValBits:0] dvd5_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inr5_q <= inr4_q;
      den5_q <= den4_q;
      for (int c = 0; c < NumChan; c++) begin
        dvd5_q[c] <= {1'b0, pl4_q[c]} + {1'b0, pr4_q[c]}
                     + {(ValBits + 1)'(0), den4_q >> 1};
      end
    end
  end

  // Divide every channel by the segment width.
  chan_t quot;

  for (genvar c = 0; c < NumChan; c++) begin : g_div
    pltl_div u_div (
      .clk_i      (clk_i),
      .en_i       (adv),
      .dividend_i (dvd5_q[c]),
      .divisor_i  (den5_q),
      .quot_o     (quot[c])
    );
  end

  // Valid and in-range flags ride alongside the divider.
  logic sv_q  [DivStages];
  logic sinr_q[DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s] <= 1'b0;
      end else if (adv) begin
        sv_q[s] <= (s == 0) ? v5_q : sv_q[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sinr_q[s] <= (s == 0) ? inr5_q : sinr_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // Output stage: optional premultiply by alpha, zeros out of range.
  logic [2*ValBits-1:0] prem [AlphaChan];
  chan_t                res;

  always_comb begin
    for (int c = 0; c < AlphaChan; c++) begin
      prem[c] = quot[c] * quot[AlphaChan] + ((2*ValBits)'(1) << (ValBits - 1));
    end
    res = quot;
    if (assoc_q) begin
      for (int c = 0; c < AlphaChan; c++) begin
        res[c] = prem[c][2*ValBits-1:ValBits];
      end
    end
    if (!sinr_q[DivStages-1]) begin
      res = '0;
    end
  end

  logic  out_v_q, out_inr_q;
  chan_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= sv_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q     <= res;
      out_inr_q <= sinr_q[DivStages-1];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[AlphaChan];
  assign in_range_o  = out_inr_q;

  // An accepted lookup always enters the pipeline.
  a_lookup_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == ReqLookup) |=> v1_q)
    else $error("accepted lookup did not enter the pipeline");

  // A write never enters the pipeline.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == ReqWrite) |=> !v1_q)
    else $error("write word entered the lookup pipeline");

  // A new result comes only from the end of the divider pipeline.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sv_q[DivStages-1]))
    else $error("result appeared without a word leaving the divider");

  // Out-of-range results carry zero channels.
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (out_q == '0))
    else $error("out-of-range result has nonzero channels");

endmodule

@@ rtl/pltl_div.sv @@
module pltl_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [2*pltl_pkg::ValBits:0]     dividend_i,
  input  logic [pltl_pkg::ValBits-1:0]     divisor_i,
  output logic [pltl_pkg::ValBits-1:0]     quot_o
);
  import pltl_pkg::*;

  // One quotient bit per stage, most significant first. The dividend is
  // known to be below divisor * 2^ValBits, so the quotient fits ValBits.
  logic [ValBits:0]   rem_q [ValBits];
  logic [ValBits-1:0] lo_q  [ValBits];
  logic [ValBits-1:0] dv_q  [ValBits];

  for (genvar g = 0; g < ValBits; g++) begin : g_stage
    logic [ValBits:0]   rin;
    logic [ValBits-1:0] lin;
    logic [ValBits-1:0] din;
    logic [ValBits+1:0] trial;
    logic [ValBits+1:0] diff;
    logic               take;

    if (g == 0) begin : g_first
      assign rin = dividend_i[2*ValBits:ValBits];
      assign lin = dividend_i[ValBits-1:0];
      assign din = divisor_i;
    end else begin : g_next
      assign rin = rem_q[g-1];
      assign lin = lo_q[g-1];
      assign din = dv_q[g-1];
    end

    // Restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rin, lin[ValBits-1]};
    assign diff  = trial - {2'b00, din};
    assign take  = (trial >= {2'b00, din});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= take ? diff[ValBits:0] : trial[ValBits:0];
        lo_q[g]  <= {lin[ValBits-2:0], take};
        dv_q[g]  <= din;
      end
    end
  end

  assign quot_o = lo_q[ValBits-1];

endmodule

@@ tb/piecewise_linear_transfer_lookup_test.sv @@
module piecewise_linear_transfer_lookup_test;
  import pltl_pkg::*;

  typedef struct {
    val_t red;
    val_t green;
    val_t blue;
    val_t alpha;
    logic in_range;
  } rgba_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [CntBits-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic req_type_i;
  logic [IdxBits-1:0] point_index_i;
  val_t point_scalar_i, point_red_i, point_green_i, point_blue_i, point_alpha_i;
  val_t sample_scalar_i;
  logic out_valid_o;
  logic out_stall_i;
  val_t out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic in_range_o;

  // Shadow copy of the table and the registers.
  val_t tbl_pos [MaxPoints];
  val_t tbl_chan [MaxPoints][NumChan];
  int unsigned points_cfg;
  logic associate_cfg;

  rgba_word_t expected_colors[$];
  int err_count;
  int unsigned cycle_count;
  int burst_left;
  int stall_mode;
  int unsigned stall_ctr;

  piecewise_linear_transfer_lookup uut (.*);

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Overall cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stall pattern; the mode changes between test phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_ctr <= 0;
    end else begin
      stall_ctr <= stall_ctr + 1;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= (stall_ctr[3:0] > 4'd10);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Interpolate the four channels for one sample from the shadow table, with premultiply and range flag.
  function automatic rgba_word_t predict_color(val_t sample);
    rgba_word_t res;
    longint unsigned ch [NumChan];
    longint unsigned pl, pr, den, num;
    int unsigned n, k;
    res = '{default: '0};
    for (int c = 0; c < NumChan; c++) ch[c] = 0;
    n = (points_cfg > MaxPoints) ? MaxPoints : points_cfg;
    if (n >= 2 && sample >= tbl_pos[0] && sample <= tbl_pos[n-1]) begin
      res.in_range = 1'b1;
      k = 0;
      while (k < n && tbl_pos[k] < sample) k++;
      if (k >= n) k = n - 1;
      if (k == 0) begin
        for (int c = 0; c < NumChan; c++) ch[c] = tbl_chan[0][c];
      end else begin
        pl = tbl_pos[k-1];
        pr = tbl_pos[k];
        if (pr <= pl || sample <= pl) begin
          for (int c = 0; c < NumChan; c++) ch[c] = tbl_chan[k][c];
        end else begin
          den = pr - pl;
          num = sample - pl;
          if (num > den) num = den;
          for (int c = 0; c < NumChan; c++)
            ch[c] = (tbl_chan[k-1][c] * (den - num) + tbl_chan[k][c] * num + den / 2) / den;
        end
      end
      // Premultiplied output scales the colors by the interpolated alpha.
      if (associate_cfg) begin
        for (int c = 0; c < AlphaChan; c++)
          ch[c] = (ch[c] * ch[AlphaChan] + 64'd32768) >> ValBits;
      end
    end
    res.red = ch[0][15:0];
    res.green = ch[1][15:0];
    res.blue = ch[2][15:0];
    res.alpha = ch[3][15:0];
    return res;
  endfunction

  // Send one word in bursts with random gaps, then update the shadow state.
  task automatic send_word(logic kind, logic [IdxBits-1:0] idx, val_t scalar,
                           val_t r, val_t g, val_t b, val_t a, val_t sample);
    int gap;
    bit accepted;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    point_index_i <= idx;
    point_scalar_i <= scalar;
    point_red_i <= r;
    point_green_i <= g;
    point_blue_i <= b;
    point_alpha_i <= a;
    sample_scalar_i <= sample;
    do begin
      @(negedge clk_i);
      accepted = !in_stall_o;
      @(posedge clk_i);
    end while (!accepted);
    if (kind == ReqWrite) begin
      tbl_pos[idx] = scalar;
      tbl_chan[idx][0] = r;
      tbl_chan[idx][1] = g;
      tbl_chan[idx][2] = b;
      tbl_chan[idx][3] = a;
    end else begin
      expected_colors.insert(expected_colors.size(), predict_color(sample));
    end
  endtask

  task automatic write_point(int idx, val_t scalar, val_t r, val_t g, val_t b, val_t a);
    send_word(ReqWrite, idx[IdxBits-1:0], scalar, r, g, b, a, val_t'($urandom));
  endtask

  task automatic lookup(val_t sample);
    send_word(ReqLookup, IdxBits'($urandom), val_t'($urandom), val_t'($urandom),
              val_t'($urandom), val_t'($urandom), val_t'($urandom), sample);
  endtask

  // Let every expected word arrive and the pipeline empty.
  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    wait (expected_colors.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CntBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPointsInUse) points_cfg = value & 5'h1f;
    else associate_cfg = value[0];
  endtask

  // Compare each accepted result word with the oldest expectation.
  always @(negedge clk_i) begin
    rgba_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected result word");
        err_count++;
      end else begin
        exp_w = expected_colors.pop_front();
        if (out_red_o !== exp_w.red) begin
          $error("out_red expected %h actual %h", exp_w.red, out_red_o);
          err_count++;
        end
        if (out_green_o !== exp_w.green) begin
          $error("out_green expected %h actual %h", exp_w.green, out_green_o);
          err_count++;
        end
        if (out_blue_o !== exp_w.blue) begin
          $error("out_blue expected %h actual %h", exp_w.blue, out_blue_o);
          err_count++;
        end
        if (out_alpha_o !== exp_w.alpha) begin
          $error("out_alpha expected %h actual %h", exp_w.alpha, out_alpha_o);
          err_count++;
        end
        if (in_range_o !== exp_w.in_range) begin
          $error("in_range expected %b actual %b", exp_w.in_range, in_range_o);
          err_count++;
        end
      end
    end
  end

  // Lookups with fewer than two points in use are out of range and give zero channels.
  task automatic test_too_few_points;
    stall_mode = 0;
    lookup(16'h0000);
    lookup(16'hffff);
    drain();
    cfg_write(RegPointsInUse, 1);
    write_point(0, 16'h0100, 16'hffff, 16'h0000, 16'h8000, 16'hffff);
    lookup(16'h0100);
    lookup(16'hffff);
    drain();
  endtask

  // Directed edges: outside span, first point, plain segment, zero-width segment.
  task automatic test_directed;
    stall_mode = 1;
    write_point(0, 16'h0010, 16'hffff, 16'h0000, 16'h1234, 16'hffff);
    write_point(1, 16'h4000, 16'h0000, 16'hffff, 16'h8001, 16'h8000);
    write_point(2, 16'h4000, 16'h5555, 16'haaaa, 16'h0000, 16'h0000);
    write_point(3, 16'hfff0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    drain();
    cfg_write(RegPointsInUse, 4);
    for (int m = 0; m < 2; m++) begin
      lookup(16'h0000);
      lookup(16'h0010);
      lookup(16'h2000);
      lookup(16'h4000);
      lookup(16'h8000);
      lookup(16'hfff0);
      lookup(16'hffff);
      drain();
      cfg_write(RegAssociate, 1);
    end
    write_point(0, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'hffff);
    write_point(1, 16'hffff, 16'hffff, 16'h0000, 16'hfffe, 16'h0001);
    drain();
    cfg_write(RegPointsInUse, 2);
    lookup(16'h0000);
    lookup(16'h7fff);
    lookup(16'hffff);
    drain();
    cfg_write(RegAssociate, 0);
  endtask

  // Fill a table of n points in non-decreasing order with random channels.
  task automatic load_table(int n, bit full_span);
    int unsigned p;
    p = full_span ? 0 : $urandom_range(0, 3000);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 7) == 0) p = p;
        else p = p + $urandom_range(1, 65535 / n + 2000);
        if (p > 65535) p = 65535;
      end
      if (full_span && i == n - 1) p = 65535;
      write_point(i, p[15:0], val_t'($urandom), val_t'($urandom), val_t'($urandom),
                  val_t'($urandom));
    end
  endtask

  // Mostly samples inside the span, some on points, some anywhere, and an occasional point rewrite.
  task automatic random_lookups(int count, int n);
    int sel;
    int unsigned lo, hi;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      lo = tbl_pos[0];
      hi = tbl_pos[n-1];
      if (sel < 6) lookup(val_t'($urandom_range(lo, hi)));
      else if (sel < 8) lookup(tbl_pos[$urandom_range(0, n - 1)]);
      else if (sel < 9) lookup(val_t'($urandom));
      else write_point($urandom_range(0, n - 1), tbl_pos[$urandom_range(0, n - 1)] == 0 ?
                       16'h0 : tbl_pos[0], val_t'($urandom), val_t'($urandom),
                       val_t'($urandom), val_t'($urandom));
    end
  endtask

  // A full table, and a register value past the table depth.
  task automatic test_full_table;
    stall_mode = 2;
    load_table(MaxPoints, 1'b1);
    drain();
    cfg_write(RegPointsInUse, MaxPoints);
    random_lookups(40, MaxPoints);
    drain();
    cfg_write(RegPointsInUse, 31);
    random_lookups(40, MaxPoints);
    drain();
  endtask

  // Random tables, sizes, modes and stall patterns.
  task automatic test_random;
    int n;
    for (int ph = 0; ph < 14; ph++) begin
      stall_mode = ph % 4;
      n = (ph == 0) ? 2 : (ph == 1) ? MaxPoints : $urandom_range(2, MaxPoints);
      cfg_write(RegPointsInUse, 0);
      load_table(n, $urandom_range(0, 3) == 0);
      drain();
      cfg_write(RegPointsInUse, n);
      cfg_write(RegAssociate, $urandom_range(0, 1));
      random_lookups(110, n);
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegPointsInUse;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = ReqWrite;
    point_index_i = '0;
    point_scalar_i = '0;
    point_red_i = '0;
    point_green_i = '0;
    point_blue_i = '0;
    point_alpha_i = '0;
    sample_scalar_i = '0;
    points_cfg = 0;
    associate_cfg = 1'b0;
    err_count = 0;
    cycle_count = 0;
    burst_left = 0;
    stall_mode = 0;
    for (int i = 0; i < MaxPoints; i++) begin
      tbl_pos[i] = '0;
      for (int c = 0; c < NumChan; c++) tbl_chan[i][c] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_too_few_points();
    test_directed();
    test_full_table();
    test_random();
    drain();

    if (err_count == 0 && expected_colors.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pltl_pkg.sv
rtl/pltl_div.sv
rtl/piecewise_linear_transfer_lookup.sv
tb/piecewise_linear_transfer_lookup_test.sv
